// ----- src/fcwh_pkg.sv -----
// Shared types and constants for the fan curve block.
package fcwh_pkg;

   localparam int unsigned PCT_W     = 7;
   localparam int unsigned SPEED_W   = 8;
   localparam int unsigned PCT_SCALE = 100;
   localparam int unsigned CSR_IDX_W = 3;

   localparam int MIN_TEMP_RST  = 400;
   localparam int MAX_TEMP_RST  = 1120;
   localparam logic [PCT_W-1:0] SPEED_LO_RST  = 7'd10;
   localparam logic [PCT_W-1:0] SPEED_HI_RST  = 7'd100;
   localparam logic [PCT_W-1:0] DROP_BAND_RST = 7'd5;
   localparam logic [PCT_W-1:0] MAX_DROP_RST  = 7'd10;
   localparam logic [SPEED_W-1:0] LAST_SPEED_RST = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_TEMP  = 3'd0,
      CSR_MAX_TEMP  = 3'd1,
      CSR_SPEED_LO  = 3'd2,
      CSR_SPEED_HI  = 3'd3,
      CSR_DROP_BAND = 3'd4,
      CSR_MAX_DROP  = 3'd5
   } csr_index_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- src/fcwh_div.sv -----
// Restoring divider, one quotient bit per cycle.
module fcwh_div #(
   parameter int unsigned NUM_W = 23,
   parameter int unsigned DEN_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     dividend,
   input  logic [DEN_W-1:0]     divisor,
   output logic [NUM_W-1:0]     quotient,
   output fcwh_pkg::div_stat_type stat
);
   import fcwh_pkg::*;

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial;

   assign trial = {rem_ff, quo_ff[NUM_W-1]} - {1'b0, den_ff};

   always_comb begin
      if (!trial[DEN_W]) begin
         rem_in = trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = {rem_ff[DEN_W-2:0], quo_ff[NUM_W-1]};
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- src/fan_curve_with_hysteresis_core.sv -----
// Top level: linear fan curve with drop hysteresis and slew limit.
// Each temperature sample maps linearly onto a fan percentage between the lower and upper speed
// limits, and the commanded speed rises at once but falls only past drop_band, by at most
// max_drop per sample. A sample passes from acceptance to result through the setup states S_PREP
// and S_MUL, a wait in S_DIV on the bit-serial restoring divider until its done flag, and the
// finishing state S_FIN; an empty curve skips the divider. req_tready is low while a sample is in
// work, so a new sample is taken only once the last one has finished. A result waits in the
// output register, and the next sample is taken meanwhile; the finishing state holds until the
// result slot is free. Write configuration only while no sample is in work; the first result
// after reset always sets write_fans.
module fan_curve_with_hysteresis_core #(
   parameter int unsigned TEMP_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   // req_tdata: temperature[TEMP_WIDTH-1:0], zero padding above
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((TEMP_WIDTH+7)/8)*8-1:0]     req_tdata,
   // rsp_tdata: speed_percent[6:0], target_percent[13:7], write_fans[14], zero[15]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,
   input  logic                                csr_we,
   input  logic [fcwh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [TEMP_WIDTH-1:0]               csr_wdata
);
   import fcwh_pkg::*;

   localparam int unsigned NUM_W = TEMP_WIDTH + 7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_MUL,
      S_DIV,
      S_FIN
   } state_type;

   state_type state_ff;

   logic signed [TEMP_WIDTH-1:0] min_temp_ff, max_temp_ff, temp_ff;
   logic [PCT_W-1:0]   speed_lo_ff, speed_hi_ff, drop_band_ff, max_drop_ff;
   logic [SPEED_W-1:0] last_speed_ff;
   logic [TEMP_WIDTH:0] diff_ff, range_ff;
   logic                empty_ff;
   logic                rsp_tvalid_ff;
   logic [PCT_W-1:0]    rsp_speed_ff, rsp_target_ff;
   logic                rsp_write_ff;

   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   logic [NUM_W-1:0]    div_quo;
   div_stat_type        div_stat;

   logic                diff_pos, range_pos;
   logic [SPEED_W-1:0]  q_sat, q_lo;
   logic [PCT_W-1:0]    target;
   logic signed [SPEED_W:0] last9, tgt9, drop9, floor9, new9;
   logic                do_write;
   logic                out_free;
   logic                req_take;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign diff_pos  = !diff_ff[TEMP_WIDTH] && (diff_ff != '0);
   assign range_pos = !range_ff[TEMP_WIDTH] && (range_ff != '0);
   assign div_num   = diff_pos ? NUM_W'(diff_ff[TEMP_WIDTH-1:0]) * NUM_W'(PCT_SCALE) : '0;
   assign div_start = (state_ff == S_MUL) && range_pos;

   fcwh_div #(
      .NUM_W (NUM_W),
      .DEN_W (TEMP_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (range_ff[TEMP_WIDTH-1:0]),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // curve target: saturate the quotient, then lower limit, then upper limit; an empty curve gives the upper limit
   always_comb begin
      q_sat = (|div_quo[NUM_W-1:SPEED_W]) ? '1 : div_quo[SPEED_W-1:0];
      q_lo  = (q_sat < {1'b0, speed_lo_ff}) ? {1'b0, speed_lo_ff} : q_sat;
      if (empty_ff) begin
         target = speed_hi_ff;
      end else if (q_lo > {1'b0, speed_hi_ff}) begin
         target = speed_hi_ff;
      end else begin
         target = q_lo[PCT_W-1:0];
      end
   end

   // hysteresis and slew limit, 9-bit signed
   always_comb begin
      last9    = {last_speed_ff[SPEED_W-1], last_speed_ff};
      tgt9     = {2'b00, target};
      drop9    = last9 - tgt9;
      floor9   = last9 - $signed({2'b00, max_drop_ff});
      do_write = (tgt9 > last9) || (drop9 > $signed({2'b00, drop_band_ff}));
      if (tgt9 < last9) begin
         new9 = (tgt9 > floor9) ? tgt9 : floor9;
      end else begin
         new9 = tgt9;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         last_speed_ff <= LAST_SPEED_RST;
         min_temp_ff   <= TEMP_WIDTH'(MIN_TEMP_RST);
         max_temp_ff   <= TEMP_WIDTH'(MAX_TEMP_RST);
         speed_lo_ff   <= SPEED_LO_RST;
         speed_hi_ff   <= SPEED_HI_RST;
         drop_band_ff  <= DROP_BAND_RST;
         max_drop_ff   <= MAX_DROP_RST;
      end else begin
         if ((state_ff == S_FIN) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_TEMP:  min_temp_ff  <= csr_wdata;
               CSR_MAX_TEMP:  max_temp_ff  <= csr_wdata;
               CSR_SPEED_LO:  speed_lo_ff  <= csr_wdata[PCT_W-1:0];
               CSR_SPEED_HI:  speed_hi_ff  <= csr_wdata[PCT_W-1:0];
               CSR_DROP_BAND: drop_band_ff <= csr_wdata[PCT_W-1:0];
               CSR_MAX_DROP:  max_drop_ff  <= csr_wdata[PCT_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  temp_ff  <= req_tdata[TEMP_WIDTH-1:0];
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               diff_ff  <= {temp_ff[TEMP_WIDTH-1], temp_ff}
                           - {min_temp_ff[TEMP_WIDTH-1], min_temp_ff};
               range_ff <= {max_temp_ff[TEMP_WIDTH-1], max_temp_ff}
                           - {min_temp_ff[TEMP_WIDTH-1], min_temp_ff};
               state_ff <= S_MUL;
            end
            S_MUL: begin
               empty_ff <= !range_pos;
               state_ff <= range_pos ? S_DIV : S_FIN;
            end
            S_DIV: begin
               if (div_stat.done) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  if (do_write) begin
                     last_speed_ff <= new9[SPEED_W-1:0];
                  end
                  rsp_speed_ff  <= do_write ? new9[PCT_W-1:0] : last_speed_ff[PCT_W-1:0];
                  rsp_target_ff <= target;
                  rsp_write_ff  <= do_write;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_write_ff, rsp_target_ff, rsp_speed_ff};

`ifndef SYNTH
   // no new sample while one is in work
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("sample accepted while busy");

   // commanded speed is never left negative once a result has been shown
   a_speed_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !last_speed_ff[SPEED_W-1])
      else $error("negative commanded speed");

   // the sequencer waits in the divide state only while the divider runs or has just finished
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("divider idle during divide state");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == S_DIV) && div_stat.busy)
      else $error("divider start out of sequence");
`endif

endmodule
